// ===== sv/sccf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccf_pkg
// Types, codes and key tables for the set-1 scancode decoder with its queue.
// ----------------------------------------------------------------------------
package sccf_pkg;

  localparam int unsigned QueueDepthDefault = 64;

  localparam logic [7:0] KeyRelease = 8'h80;
  localparam logic [6:0] KeyLShift  = 7'h2A;
  localparam logic [6:0] KeyRShift  = 7'h36;
  localparam logic [6:0] KeyCtrl    = 7'h1D;
  localparam logic [6:0] KeyAlt     = 7'h38;
  localparam logic [6:0] KeyCaps    = 7'h3A;
  localparam logic [6:0] TableLen   = 7'd58;
  localparam logic [7:0] CaseStep   = 8'd32;

  localparam logic KindScan = 1'b0;
  localparam logic KindRead = 1'b1;

  // Mode codes as seen on the result channel
  localparam logic [2:0] ModeCodeNormal    = 3'd0;
  localparam logic [2:0] ModeCodeShift     = 3'd1;
  localparam logic [2:0] ModeCodeCaps      = 3'd2;
  localparam logic [2:0] ModeCodeShiftCaps = 3'd3;
  localparam logic [2:0] ModeCodeCtrl      = 3'd4;
  localparam logic [2:0] ModeCodeAlt       = 3'd5;

  typedef enum logic [5:0] {
    MODE_NORMAL     = 6'b000001,
    MODE_SHIFT      = 6'b000010,
    MODE_CAPS       = 6'b000100,
    MODE_SHIFT_CAPS = 6'b001000,
    MODE_CTRL       = 6'b010000,
    MODE_ALT        = 6'b100000
  } mode_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] scancode;
  } scan_in_t;

  typedef struct packed {
    logic [6:0] char_out;
    logic       char_valid;
    logic       char_stored;
    logic       char_dropped;
    logic [2:0] mode_now;
  } char_res_t;

  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] c;
    case (m)
      MODE_NORMAL:     c = ModeCodeNormal;
      MODE_SHIFT:      c = ModeCodeShift;
      MODE_CAPS:       c = ModeCodeCaps;
      MODE_SHIFT_CAPS: c = ModeCodeShiftCaps;
      MODE_CTRL:       c = ModeCodeCtrl;
      MODE_ALT:        c = ModeCodeAlt;
      default:         c = ModeCodeNormal;
    endcase
    return c;
  endfunction

  function automatic mode_e next_mode(mode_e m, logic [7:0] code);
    logic       up;
    logic [6:0] k;
    logic       shift;
    mode_e      n;
    up    = (code & KeyRelease) != 8'h00;
    k     = code[6:0];
    shift = (k == KeyLShift) || (k == KeyRShift);
    n     = m;
    case (m)
      MODE_NORMAL: begin
        if (!up) begin
          if (shift)                n = MODE_SHIFT;
          else if (k == KeyCtrl)    n = MODE_CTRL;
          else if (k == KeyAlt)     n = MODE_ALT;
          else if (k == KeyCaps)    n = MODE_CAPS;
        end
      end
      MODE_SHIFT: begin
        if (up && shift)               n = MODE_NORMAL;
        else if (!up && k == KeyCaps)  n = MODE_SHIFT_CAPS;
      end
      MODE_CAPS: begin
        if (!up && k == KeyCaps)       n = MODE_NORMAL;
        else if (!up && shift)         n = MODE_SHIFT_CAPS;
      end
      MODE_SHIFT_CAPS: begin
        if (up && shift)               n = MODE_CAPS;
        else if (!up && k == KeyCaps)  n = MODE_SHIFT;
      end
      MODE_CTRL: begin
        if (up && k == KeyCtrl)        n = MODE_NORMAL;
      end
      MODE_ALT: begin
        if (up && k == KeyAlt)         n = MODE_NORMAL;
      end
      default: n = m;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] plain_map(logic [5:0] k);
    logic [7:0] c;
    case (k)
      6'd1:  c = 8'd27;
      6'd2:  c = "1";
      6'd3:  c = "2";
      6'd4:  c = "3";
      6'd5:  c = "4";
      6'd6:  c = "5";
      6'd7:  c = "6";
      6'd8:  c = "7";
      6'd9:  c = "8";
      6'd10: c = "9";
      6'd11: c = "0";
      6'd12: c = ")";
      6'd13: c = "^";
      6'd14: c = 8'd8;
      6'd15: c = 8'd9;
      6'd16: c = "a";
      6'd17: c = "z";
      6'd18: c = "e";
      6'd19: c = "r";
      6'd20: c = "t";
      6'd21: c = "y";
      6'd22: c = "u";
      6'd23: c = "i";
      6'd24: c = "o";
      6'd25: c = "p";
      6'd26: c = "^";
      6'd27: c = "$";
      6'd28: c = 8'd10;
      6'd30: c = "q";
      6'd31: c = "s";
      6'd32: c = "d";
      6'd33: c = "f";
      6'd34: c = "g";
      6'd35: c = "h";
      6'd36: c = "j";
      6'd37: c = "k";
      6'd38: c = "l";
      6'd39: c = "m";
      6'd40: c = "%";
      6'd41: c = "*";
      6'd43: c = "*";
      6'd44: c = "w";
      6'd45: c = "x";
      6'd46: c = "c";
      6'd47: c = "v";
      6'd48: c = "b";
      6'd49: c = "n";
      6'd50: c = ",";
      6'd51: c = ";";
      6'd52: c = ":";
      6'd53: c = "!";
      6'd57: c = " ";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] upper_map(logic [5:0] k);
    logic [7:0] c;
    case (k)
      6'd1:  c = 8'd27;
      6'd2:  c = "!";
      6'd3:  c = "@";
      6'd4:  c = "#";
      6'd5:  c = "$";
      6'd6:  c = "%";
      6'd7:  c = "^";
      6'd8:  c = "&";
      6'd9:  c = "*";
      6'd10: c = "(";
      6'd11: c = ")";
      6'd13: c = "+";
      6'd14: c = 8'd8;
      6'd15: c = 8'd9;
      6'd16: c = "A";
      6'd17: c = "Z";
      6'd18: c = "E";
      6'd19: c = "R";
      6'd20: c = "T";
      6'd21: c = "Y";
      6'd22: c = "U";
      6'd23: c = "I";
      6'd24: c = "O";
      6'd25: c = "P";
      6'd26: c = "{";
      6'd27: c = "}";
      6'd28: c = 8'd10;
      6'd30: c = "Q";
      6'd31: c = "S";
      6'd32: c = "D";
      6'd33: c = "F";
      6'd34: c = "G";
      6'd35: c = "H";
      6'd36: c = "J";
      6'd37: c = "K";
      6'd38: c = "L";
      6'd39: c = "M";
      6'd40: c = "/";
      6'd41: c = "~";
      6'd43: c = "|";
      6'd44: c = "W";
      6'd45: c = "X";
      6'd46: c = "C";
      6'd47: c = "V";
      6'd48: c = "B";
      6'd49: c = "N";
      6'd50: c = "?";
      6'd51: c = ".";
      6'd52: c = "/";
      6'd53: c = "_";
      6'd57: c = " ";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // Character for a pressed key in the given mode, zero for none
  function automatic logic [6:0] key_char(logic [6:0] k, mode_e m);
    logic [7:0] c;
    c = 8'd0;
    if (k < TableLen) begin
      case (m)
        MODE_NORMAL: c = plain_map(k[5:0]);
        MODE_SHIFT:  c = upper_map(k[5:0]);
        MODE_CAPS: begin
          c = plain_map(k[5:0]);
          if (c >= "a" && c <= "z") c = c - CaseStep;
        end
        MODE_SHIFT_CAPS: begin
          c = upper_map(k[5:0]);
          if (c >= "A" && c <= "Z") c = c + CaseStep;
        end
        default: c = 8'd0;
      endcase
    end
    return c[6:0];
  endfunction

endpackage

// ===== sv/scancode_to_char_fifo_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_char_fifo_core
// Set-1 scancode to character decoder feeding a character ring buffer.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------
//  in       | input     | in_valid_i/in_ready_o  | in_data_i  (scan_in_t)
//  out      | output    | out_valid_o/out_ready_i| out_data_o (char_res_t)
//
//  One transfer per cycle while the output does not stall; a result passes
//  decode and ring access, then the output register with the ring data.
//  Mode and ring indices update at the input transfer; the ring memory is
//  written there and read into a data register in the same edge.
//  Reset clears mode and indices at once; the ring needs no clearing pass.
//  A stalled output holds both stages; input stays open while a stage is free.
// ----------------------------------------------------------------------------
module scancode_to_char_fifo_core
  import sccf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  scan_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output char_res_t out_data_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(QUEUE_DEPTH - 1);

  logic [6:0] mem_q [QUEUE_DEPTH];
  logic [6:0] rdata_q;

  mode_e         mode_q, mode_d;
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d, wr_inc, rd_inc;

  logic      s1_valid_q, s2_valid_q;
  char_res_t s1_res_q, s1_res_d, s2_res_q, s2_res_d;
  logic      s1_adv, in_xfer;
  logic      push, pop, full, empty;
  logic [6:0] ch;

  assign s1_adv     = !s2_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign wr_inc = (wr_q == LastIdx) ? '0 : wr_q + AW'(1);
  assign rd_inc = (rd_q == LastIdx) ? '0 : rd_q + AW'(1);
  assign full   = (wr_inc == rd_q);
  assign empty  = (wr_q == rd_q);

  always_comb begin
    mode_d   = mode_q;
    wr_d     = wr_q;
    rd_d     = rd_q;
    push     = 1'b0;
    pop      = 1'b0;
    ch       = '0;
    s1_res_d = '0;
    if (in_xfer) begin
      if (in_data_i.kind == KindScan) begin
        mode_d = next_mode(mode_q, in_data_i.scancode);
        if ((in_data_i.scancode & KeyRelease) == 8'h00) begin
          ch = key_char(in_data_i.scancode[6:0], mode_d);
        end
        if (ch != '0) begin
          if (!full) begin
            push                 = 1'b1;
            wr_d                 = wr_inc;
            s1_res_d.char_stored = 1'b1;
          end else begin
            s1_res_d.char_dropped = 1'b1;
          end
        end
      end else if (!empty) begin
        pop                 = 1'b1;
        rd_d                = rd_inc;
        s1_res_d.char_valid = 1'b1;
      end
      s1_res_d.mode_now = mode_code(mode_d);
    end
  end

  // Ring storage: write on push, registered read on pop
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= ch;
    end
    if (pop) begin
      rdata_q <= mem_q[rd_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_NORMAL;
      wr_q       <= '0;
      rd_q       <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      if (in_ready_o) begin
        s1_valid_q <= in_xfer;
      end
      if (s1_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Merge the ring read data into the result as it advances
  always_comb begin
    s2_res_d          = s1_res_q;
    s2_res_d.char_out = s1_res_q.char_valid ? rdata_q : 7'd0;
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_res_q <= s1_res_d;
    end
    if (s1_adv && s1_valid_q) begin
      s2_res_q <= s2_res_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_res_q;

  // A queued character is never zero, so a popped one is not either
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.char_valid |-> out_data_o.char_out != 7'd0)
    else $error("popped character is zero");

  // A push never fills the last free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> wr_q != rd_q)
    else $error("ring indices met after push");

  // Ctrl and alt modes produce no character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.char_stored || out_data_o.char_dropped) |->
      out_data_o.mode_now != ModeCodeCtrl && out_data_o.mode_now != ModeCodeAlt)
    else $error("character produced in ctrl or alt mode");

  // A stalled result holds its place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule
